>>> src/iirl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and codes for the indexed insert/remove list
// Command and status codes used on the ports of the list core.
// ----------------------------------------------------------------------------
package iirl_pkg;

	typedef logic [2:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_APPEND = 3'd0;
	localparam cmd_t CMD_DROP   = 3'd1;
	localparam cmd_t CMD_INSERT = 3'd2;
	localparam cmd_t CMD_REMOVE = 3'd3;
	localparam cmd_t CMD_DUMP   = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam int COUNT_BITS = 7;
	localparam int DATA_BITS  = 32;

endpackage

>>> src/indexed_insert_remove_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core: bounded ordered list with indexed edits
// Holds up to CAPACITY words in a synchronous RAM plus a count. Supports
// append, drop last, insert/remove at index (shifting the tail) and dump.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start (in), busy (out)  cmd, value, index
//  result    done (out, 1 cycle)  status, count, data, last
//
//  Append, drop, rejected commands and unknown codes: result next cycle.
//  Insert at i below n and remove at i below n - 1 shift the tail; either one
//  at the tail moves no word. The tail moves one word per cycle through the
//  single RAM port pair (read, then write back).
//  Dump: one element per cycle, each read through the registered RAM output.
//  Reset clears the count and control; the RAM contents are not cleared.
//  The receiver cannot stall: each result is shown on done for one cycle.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core #(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  iirl_pkg::cmd_t                      cmd,
	input  logic [iirl_pkg::DATA_BITS-1:0]      value,
	input  logic [5:0]                          index,
	output logic                                done,
	output iirl_pkg::status_t                   status,
	output logic [iirl_pkg::COUNT_BITS-1:0]     count,
	output logic [iirl_pkg::DATA_BITS-1:0]      data,
	output logic                                last
);
	import iirl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_DUMP
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              elem_cnt_q;
	logic [CW-1:0]              ptr_q;
	logic [CW-1:0]              idx_q;
	logic                       ins_q;
	logic [WORD_BITS-1:0]       val_q;
	logic                       wr_v_s1;
	logic [AW-1:0]              wa_s1;
	logic                       rd_v_s1;
	logic                       last_s1;

	logic                       done_q;
	status_t                    status_q;
	logic [COUNT_BITS-1:0]      count_q;
	logic [DATA_BITS-1:0]       data_q;
	logic                       last_q;

	logic [WORD_BITS-1:0]       mem [CAPACITY];
	logic [WORD_BITS-1:0]       rdata_q;

	logic                       we_c;
	logic [AW-1:0]              wa_c;
	logic [WORD_BITS-1:0]       wd_c;
	logic [CW-1:0]              ra_c;

	logic                       full_c;
	logic [COUNT_BITS-1:0]      idx7_c;
	logic [COUNT_BITS-1:0]      cnt7_c;
	logic                       more_c;
	logic                       issue_c;
	logic [CW-1:0]              ptr_dn_c;
	logic [CW-1:0]              ptr_up_c;
	logic [WORD_BITS-1:0]       val_c;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign count  = count_q;
	assign data   = data_q;
	assign last   = last_q;

	assign full_c   = (elem_cnt_q == CW'(CAPACITY));
	assign idx7_c   = COUNT_BITS'(index);
	assign cnt7_c   = COUNT_BITS'(elem_cnt_q);
	assign ptr_dn_c = ptr_q - 1'b1;
	assign ptr_up_c = ptr_q + 1'b1;
	assign val_c    = WORD_BITS'(value);
	// insert walks down from the count to the index; remove walks up to count-1
	assign more_c   = ins_q ? (ptr_q > idx_q) : (ptr_up_c < elem_cnt_q);
	assign issue_c  = (ptr_q < elem_cnt_q);

	always_comb begin
		we_c = 1'b0;
		wa_c = elem_cnt_q[AW-1:0];
		wd_c = val_c;
		ra_c = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (start && cmd == CMD_APPEND && !full_c) begin
					we_c = 1'b1;
				end
			end
			S_SHIFT: begin
				ra_c = ins_q ? ptr_dn_c : ptr_up_c;
				if (wr_v_s1) begin
					we_c = 1'b1;
					wa_c = wa_s1;
					wd_c = rdata_q;
				end else if (!more_c && ins_q) begin
					we_c = 1'b1;
					wa_c = idx_q[AW-1:0];
					wd_c = val_q;
				end
			end
			default: begin
				ra_c = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		rdata_q <= mem[ra_c[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			elem_cnt_q <= '0;
			ptr_q      <= '0;
			idx_q      <= '0;
			ins_q      <= 1'b0;
			val_q      <= '0;
			wr_v_s1    <= 1'b0;
			wa_s1      <= '0;
			rd_v_s1    <= 1'b0;
			last_s1    <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			count_q    <= '0;
			data_q     <= '0;
			last_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					wr_v_s1 <= 1'b0;
					rd_v_s1 <= 1'b0;
					if (start) begin
						status_q <= ST_OK;
						count_q  <= cnt7_c;
						data_q   <= '0;
						last_q   <= 1'b1;
						idx_q    <= CW'(index);
						val_q    <= val_c;
						case (cmd)
							CMD_APPEND: begin
								done_q <= 1'b1;
								if (full_c) begin
									status_q <= ST_FULL;
								end else begin
									elem_cnt_q <= elem_cnt_q + 1'b1;
									count_q    <= cnt7_c + 1'b1;
								end
							end
							CMD_DROP: begin
								done_q <= 1'b1;
								if (elem_cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									elem_cnt_q <= elem_cnt_q - 1'b1;
									count_q    <= cnt7_c - 1'b1;
								end
							end
							CMD_INSERT: begin
								if (idx7_c > cnt7_c) begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
								end else if (full_c) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else begin
									ins_q   <= 1'b1;
									ptr_q   <= elem_cnt_q;
									state_q <= S_SHIFT;
								end
							end
							CMD_REMOVE: begin
								if (idx7_c >= cnt7_c) begin
									done_q   <= 1'b1;
									status_q <= ST_RANGE;
								end else begin
									ins_q   <= 1'b0;
									ptr_q   <= CW'(index);
									state_q <= S_SHIFT;
								end
							end
							CMD_DUMP: begin
								if (elem_cnt_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									ptr_q   <= '0;
									state_q <= S_DUMP;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// read of the neighbor now, write to ptr next cycle
					wr_v_s1 <= more_c;
					wa_s1   <= ptr_q[AW-1:0];
					if (more_c) begin
						ptr_q <= ins_q ? ptr_dn_c : ptr_up_c;
					end else if (!wr_v_s1) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						data_q   <= '0;
						last_q   <= 1'b1;
						if (ins_q) begin
							elem_cnt_q <= elem_cnt_q + 1'b1;
							count_q    <= cnt7_c + 1'b1;
						end else begin
							elem_cnt_q <= elem_cnt_q - 1'b1;
							count_q    <= cnt7_c - 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					rd_v_s1 <= issue_c;
					last_s1 <= (ptr_up_c == elem_cnt_q);
					if (issue_c) begin
						ptr_q <= ptr_up_c;
					end
					if (rd_v_s1) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						count_q  <= cnt7_c;
						data_q   <= DATA_BITS'(rdata_q);
						last_q   <= last_s1;
						if (last_s1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		elem_cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !wr_v_s1 && !rd_v_s1)
		else $error("pipeline not drained in idle");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_APPEND || cmd == CMD_DROP) |=> done && last && !busy)
		else $error("append/drop did not complete in one cycle");

	a_stream_open: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy && state_q == S_DUMP)
		else $error("non-final result outside a dump");

	a_dump_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && state_q != S_DUMP && $past(state_q) != S_DUMP |-> data == '0)
		else $error("nonzero data outside a dump");
`endif

endmodule
